@@ rtl/core/assert_macros.svh @@
// assertion macros included by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/spq_pkg.sv @@
// types, codes and defaults shared by the priority queue rtl
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_BITS_DEF  = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int PAY_BITS      = 8;

  // operation codes
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_SEARCH = 3'd2;
  localparam logic [2:0] FN_CHANGE = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BEYOND   = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] key;
    logic [7:0]  payload;
    logic [7:0]  priority_req;
    logic [5:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_position;
    logic [15:0] out_key;
    logic [7:0]  out_payload;
    logic [7:0]  out_priority;
    logic [6:0]  entry_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RECMP,
    S_REINS
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       occ;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic ins;
  } cell_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/sorted_priority_queue_by_key_core.sv @@
// top level of the shift-register priority queue ordered by descending priority
// result: strobe registered out of the execute state, or the reinsert state for change priority
// operations: busy until idle again, so none is taken before the last is done; change priority
//   runs a remove pass, recompare and insert pass, shifting on the cell row's registered compare
// reset: synchronous active-low, empties the queue and returns to idle; slot data is not cleared
// the result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none

module sorted_priority_queue_by_key_core #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  spq_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output spq_pkg::out_item_t  out_item
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMPW  = (CNT_W > 6) ? CNT_W : 6;
  localparam int IDXE  = (IDX_W > 6) ? IDX_W : 6;
  localparam int CNTE  = (CNT_W > 7) ? CNT_W : 7;
  localparam int KEYE  = (KEY_BITS > 16) ? KEY_BITS : 16;
  localparam int PRIOE = (PRIO_BITS > 8) ? PRIO_BITS : 8;
  localparam int PW    = spq_pkg::PAY_BITS;

  // control state
  spq_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_strobe_r;
  spq_pkg::out_item_t  res_r, res_nxt;
  logic                res_load;

  // latched command and the entry being placed
  logic [2:0]          func_r;
  logic [5:0]          pos_r;
  logic [KEY_BITS-1:0] ent_key_r;
  logic [PW-1:0]       ent_pay_r;
  logic [PRIO_BITS-1:0] ent_prio_r;

  logic accept;
  assign busy   = (state_r != spq_pkg::S_IDLE);
  assign accept = start && !busy;

  // input fields trimmed to the stored widths
  logic [KEYE-1:0]      in_key_x;
  logic [PRIOE-1:0]     in_prio_x;
  logic [KEY_BITS-1:0]  in_key_c;
  logic [PRIO_BITS-1:0] in_prio_c;
  assign in_key_x  = KEYE'(in_item.key);
  assign in_prio_x = PRIOE'(in_item.priority_req);
  assign in_key_c  = in_key_x[KEY_BITS-1:0];
  assign in_prio_c = in_prio_x[PRIO_BITS-1:0];

  // compare broadcast: straight from the ports on a transfer, else the latched entry
  logic [KEY_BITS-1:0]  cmp_key;
  logic [PRIO_BITS-1:0] cmp_prio;
  assign cmp_key  = (state_r == spq_pkg::S_IDLE) ? in_key_c  : ent_key_r;
  assign cmp_prio = (state_r == spq_pkg::S_IDLE) ? in_prio_c : ent_prio_r;

  // cell row
  spq_pkg::cell_mode_t  mode;
  logic [KEY_BITS-1:0]  c_key  [DEPTH];
  logic [PW-1:0]        c_pay  [DEPTH];
  logic [PRIO_BITS-1:0] c_prio [DEPTH];
  spq_pkg::cell_flags_t c_flags[DEPTH];
  logic [DEPTH-1:0]     c_after;
  logic [DEPTH-1:0]     sel_m, sel_i, sel_p, sel;

  logic [CMPW-1:0] pos_w, cnt_w;
  assign pos_w = CMPW'(pos_r);
  assign cnt_w = CMPW'(count_r);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_ctl_t   ctl;
    logic [KEY_BITS-1:0]  l_key,  r_key;
    logic [PW-1:0]        l_pay,  r_pay;
    logic [PRIO_BITS-1:0] l_prio, r_prio;
    logic                 l_ins,  l_after;

    assign ctl.mode = mode;
    assign ctl.occ  = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_key   = '0;
      assign l_pay   = '0;
      assign l_prio  = '0;
      assign l_ins   = 1'b0;
      assign l_after = 1'b0;
    end else begin : g_body
      assign l_key   = c_key[i-1];
      assign l_pay   = c_pay[i-1];
      assign l_prio  = c_prio[i-1];
      assign l_ins   = c_flags[i-1].ins;
      assign l_after = c_after[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_key  = c_key[i];
      assign r_pay  = c_pay[i];
      assign r_prio = c_prio[i];
    end else begin : g_mid
      assign r_key  = c_key[i+1];
      assign r_pay  = c_pay[i+1];
      assign r_prio = c_prio[i+1];
    end

    spq_cell #(
      .KEY_BITS  (KEY_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cmp_key    (cmp_key),
      .cmp_prio   (cmp_prio),
      .new_key    (ent_key_r),
      .new_pay    (ent_pay_r),
      .new_prio   (ent_prio_r),
      .left_key   (l_key),
      .left_pay   (l_pay),
      .left_prio  (l_prio),
      .left_ins   (l_ins),
      .left_after (l_after),
      .right_key  (r_key),
      .right_pay  (r_pay),
      .right_prio (r_prio),
      .key_o      (c_key[i]),
      .pay_o      (c_pay[i]),
      .prio_o     (c_prio[i]),
      .flags_o    (c_flags[i]),
      .after_o    (c_after[i])
    );

    // first key match, insert slot (edge of the sorted prefix) and read slot
    assign sel_m[i] = c_flags[i].match && !l_after;
    assign sel_i[i] = c_flags[i].ins && !l_ins;
    assign sel_p[i] = (CMPW'(i) == pos_w);
  end

  logic found, full, beyond;
  assign found  = c_after[DEPTH-1];
  assign full   = (count_r == CNT_W'(DEPTH));
  assign beyond = (pos_w >= cnt_w);

  assign sel = ((state_r == spq_pkg::S_REINS) || (func_r == spq_pkg::FN_INSERT)) ? sel_i :
               (func_r == spq_pkg::FN_READ) ? sel_p : sel_m;

  // gather the selected slot through a one-hot or
  logic [KEY_BITS-1:0]  g_key;
  logic [PW-1:0]        g_pay;
  logic [PRIO_BITS-1:0] g_prio;
  logic [IDX_W-1:0]     g_idx;

  always_comb begin
    g_key  = '0;
    g_pay  = '0;
    g_prio = '0;
    g_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        g_key  = g_key  | c_key[i];
        g_pay  = g_pay  | c_pay[i];
        g_prio = g_prio | c_prio[i];
        g_idx  = g_idx  | IDX_W'(i);
      end
    end
  end

  // result field widths
  logic [IDXE-1:0]  g_idx_x;
  logic [KEYE-1:0]  g_key_x, ent_key_x;
  logic [PRIOE-1:0] g_prio_x, ent_prio_x;
  logic [CNTE-1:0]  cnt_nxt_x;
  assign g_idx_x    = IDXE'(g_idx);
  assign g_key_x    = KEYE'(g_key);
  assign ent_key_x  = KEYE'(ent_key_r);
  assign g_prio_x   = PRIOE'(g_prio);
  assign ent_prio_x = PRIOE'(ent_prio_r);
  assign cnt_nxt_x  = CNTE'(count_nxt);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) state_nxt = spq_pkg::S_EXEC;
      end
      spq_pkg::S_EXEC: begin
        if (func_r == spq_pkg::FN_CHANGE && found) state_nxt = spq_pkg::S_RECMP;
        else state_nxt = spq_pkg::S_IDLE;
      end
      spq_pkg::S_RECMP: state_nxt = spq_pkg::S_REINS;
      spq_pkg::S_REINS: state_nxt = spq_pkg::S_IDLE;
      default:          state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  // row control, count and result
  always_comb begin
    mode      = spq_pkg::CM_HOLD;
    count_nxt = count_r;
    res_load  = 1'b0;
    res_nxt   = '0;
    unique case (state_r)
      spq_pkg::S_EXEC: begin
        res_load = 1'b1;
        unique case (func_r)
          spq_pkg::FN_INSERT: begin
            if (full) begin
              res_nxt.status = spq_pkg::ST_FULL;
            end else begin
              mode                 = spq_pkg::CM_INSERT;
              count_nxt            = count_r + CNT_W'(1);
              res_nxt.out_position = g_idx_x[5:0];
              res_nxt.out_key      = ent_key_x[15:0];
              res_nxt.out_payload  = ent_pay_r;
              res_nxt.out_priority = ent_prio_x[7:0];
            end
          end
          spq_pkg::FN_REMOVE, spq_pkg::FN_SEARCH, spq_pkg::FN_CHANGE: begin
            if (!found) begin
              res_nxt.status = spq_pkg::ST_NOTFOUND;
            end else begin
              res_nxt.out_position = g_idx_x[5:0];
              res_nxt.out_key      = g_key_x[15:0];
              res_nxt.out_payload  = g_pay;
              res_nxt.out_priority = g_prio_x[7:0];
              if (func_r != spq_pkg::FN_SEARCH) begin
                mode      = spq_pkg::CM_REMOVE;
                count_nxt = count_r - CNT_W'(1);
              end
              // change priority reports after the reinsert pass
              if (func_r == spq_pkg::FN_CHANGE) res_load = 1'b0;
            end
          end
          spq_pkg::FN_READ: begin
            if (beyond) begin
              res_nxt.status = spq_pkg::ST_BEYOND;
            end else begin
              res_nxt.out_position = g_idx_x[5:0];
              res_nxt.out_key      = g_key_x[15:0];
              res_nxt.out_payload  = g_pay;
              res_nxt.out_priority = g_prio_x[7:0];
            end
          end
          default: begin
          end
        endcase
      end
      spq_pkg::S_REINS: begin
        res_load             = 1'b1;
        mode                 = spq_pkg::CM_INSERT;
        count_nxt            = count_r + CNT_W'(1);
        res_nxt.out_position = g_idx_x[5:0];
        res_nxt.out_key      = ent_key_x[15:0];
        res_nxt.out_payload  = ent_pay_r;
        res_nxt.out_priority = ent_prio_x[7:0];
      end
      default: begin
      end
    endcase
    res_nxt.entry_count = cnt_nxt_x[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spq_pkg::S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= res_load;
    end
  end

  // command and entry registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_item.func;
      pos_r      <= in_item.position;
      ent_key_r  <= in_key_c;
      ent_pay_r  <= in_item.payload;
      ent_prio_r <= in_prio_c;
    end else if (state_r == spq_pkg::S_EXEC && func_r == spq_pkg::FN_CHANGE) begin
      // keep the matched entry for the reinsert pass
      ent_key_r <= g_key;
      ent_pay_r <= g_pay;
    end
    if (res_load) res_r <= res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = res_r;

  // checks
  `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_reins_strobe, clk, rst_n, state_r == spq_pkg::S_REINS, out_strobe_r)
  `ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == spq_pkg::S_EXEC)
  `ASSERT_IMPLY(a_full_status, clk, rst_n,
    out_strobe_r && res_r.status == spq_pkg::ST_FULL, count_r == CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// one queue slot: holds an entry, compares against the broadcast, shifts with neighbors
`default_nettype none

module spq_cell #(
  parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  wire                             clk,
  input  spq_pkg::cell_ctl_t              ctl,
  input  wire [KEY_BITS-1:0]              cmp_key,
  input  wire [PRIO_BITS-1:0]             cmp_prio,
  input  wire [KEY_BITS-1:0]              new_key,
  input  wire [spq_pkg::PAY_BITS-1:0]     new_pay,
  input  wire [PRIO_BITS-1:0]             new_prio,
  input  wire [KEY_BITS-1:0]              left_key,
  input  wire [spq_pkg::PAY_BITS-1:0]     left_pay,
  input  wire [PRIO_BITS-1:0]             left_prio,
  input  wire                             left_ins,
  input  wire                             left_after,
  input  wire [KEY_BITS-1:0]              right_key,
  input  wire [spq_pkg::PAY_BITS-1:0]     right_pay,
  input  wire [PRIO_BITS-1:0]             right_prio,
  output logic [KEY_BITS-1:0]             key_o,
  output logic [spq_pkg::PAY_BITS-1:0]    pay_o,
  output logic [PRIO_BITS-1:0]            prio_o,
  output spq_pkg::cell_flags_t            flags_o,
  output logic                            after_o
);

  logic [KEY_BITS-1:0]          key_r,  key_nxt;
  logic [spq_pkg::PAY_BITS-1:0] pay_r,  pay_nxt;
  logic [PRIO_BITS-1:0]         prio_r, prio_nxt;
  spq_pkg::cell_flags_t         flags_r, flags_nxt;

  // at or behind the first key match
  assign after_o = flags_r.match | left_after;

  always_comb begin
    flags_nxt.match = ctl.occ && (cmp_key == key_r);
    flags_nxt.ins   = !ctl.occ || (cmp_prio > prio_r);
  end

  always_comb begin
    key_nxt  = key_r;
    pay_nxt  = pay_r;
    prio_nxt = prio_r;
    unique case (ctl.mode)
      spq_pkg::CM_INSERT: begin
        if (left_ins) begin
          key_nxt  = left_key;
          pay_nxt  = left_pay;
          prio_nxt = left_prio;
        end else if (flags_r.ins) begin
          key_nxt  = new_key;
          pay_nxt  = new_pay;
          prio_nxt = new_prio;
        end
      end
      spq_pkg::CM_REMOVE: begin
        if (after_o) begin
          key_nxt  = right_key;
          pay_nxt  = right_pay;
          prio_nxt = right_prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    pay_r   <= pay_nxt;
    prio_r  <= prio_nxt;
    flags_r <= flags_nxt;
  end

  assign key_o   = key_r;
  assign pay_o   = pay_r;
  assign prio_o  = prio_r;
  assign flags_o = flags_r;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the shift-register priority queue ordered by priority
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = spq_pkg::DEPTH_DEF;
  localparam int KEY_POOL = 24;

  // highest func code, the ones above FN_READ are spare and change nothing
  localparam logic [2:0] FN_LAST_CODE = 3'd7;

  // what the driver does with one pending record
  typedef enum logic [1:0] {
    PK_ITEM,
    PK_IDLE,
    PK_DRAIN
  } pend_kind_t;

  typedef struct packed {
    pend_kind_t        kind;
    spq_pkg::in_item_t op;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  spq_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_strobe;
  spq_pkg::out_item_t out_item;

  // stimulus waiting for the driver, and results still owed by the block
  pending_t           pending_q[$];
  spq_pkg::out_item_t expected_results[$];

  // the testbench's own copy of the queue contents
  logic [15:0] store_key [DEPTH];
  logic [7:0]  store_pay [DEPTH];
  logic [7:0]  store_prio[DEPTH];
  int          held_entries = 0;

  logic [15:0] key_pool[KEY_POOL];

  int ops_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int phase_idle[4] = '{0, 48, 0, 31};

  sorted_priority_queue_by_key_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // queue model
  // -------------------------------------------------------------------------

  // new entry goes behind every entry of equal or higher priority
  function automatic int place_entry(logic [15:0] k, logic [7:0] pay, logic [7:0] pr);
    int i;
    i = held_entries;
    while (i > 0 && pr > store_prio[i-1]) begin
      store_key[i]  = store_key[i-1];
      store_pay[i]  = store_pay[i-1];
      store_prio[i] = store_prio[i-1];
      i--;
    end
    store_key[i]  = k;
    store_pay[i]  = pay;
    store_prio[i] = pr;
    held_entries++;
    return i;
  endfunction

  // take out one entry and close the gap behind it
  function automatic void drop_entry(int idx);
    for (int j = idx; j + 1 < held_entries; j++) begin
      store_key[j]  = store_key[j+1];
      store_pay[j]  = store_pay[j+1];
      store_prio[j] = store_prio[j+1];
    end
    held_entries--;
  endfunction

  // apply one operation to the model and return the result it must produce
  function automatic spq_pkg::out_item_t predict_queue_op(spq_pkg::in_item_t op);
    spq_pkg::out_item_t r;
    int                 idx;
    bit                 report;
    bit                 drop;
    logic [15:0]        k;
    logic [7:0]         pay;
    r = '0;
    idx = 0;
    report = 1'b0;
    drop = 1'b0;
    case (op.func)
      spq_pkg::FN_INSERT: begin
        if (held_entries >= DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          idx = place_entry(op.key, op.payload, op.priority_req);
          report = 1'b1;
        end
      end
      spq_pkg::FN_REMOVE, spq_pkg::FN_SEARCH, spq_pkg::FN_CHANGE: begin
        // first match from the head wins when keys repeat
        while (idx < held_entries && store_key[idx] != op.key) idx++;
        if (idx >= held_entries) begin
          r.status = spq_pkg::ST_NOTFOUND;
        end else begin
          report = 1'b1;
          // remove reports the entry as it stood before it goes
          drop = (op.func == spq_pkg::FN_REMOVE);
          if (op.func == spq_pkg::FN_CHANGE) begin
            k = store_key[idx];
            pay = store_pay[idx];
            drop_entry(idx);
            idx = place_entry(k, pay, op.priority_req);
          end
        end
      end
      spq_pkg::FN_READ: begin
        if (op.position >= held_entries) begin
          r.status = spq_pkg::ST_BEYOND;
        end else begin
          idx = op.position;
          report = 1'b1;
        end
      end
      default: begin
        // spare codes: ok status, empty entry fields, count unchanged
      end
    endcase
    if (report) begin
      r.out_position = 6'(idx);
      r.out_key      = store_key[idx];
      r.out_payload  = store_pay[idx];
      r.out_priority = store_prio[idx];
    end
    if (drop) drop_entry(idx);
    r.entry_count = 7'(held_entries);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // driver: one pending record per free cycle, start held while busy
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ops
    pending_t rec;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // transfer happens at this edge, predict it in order of acceptance
      if (start && !busy) begin
        expected_results.push_back(predict_queue_op(in_item));
        ops_sent++;
      end
      // at most one assignment to start per edge, none while a start waits on busy
      if (!start || !busy) begin
        if (pending_q.size() == 0) begin
          start <= 1'b0;
        end else begin
          rec = pending_q[0];
          start <= (rec.kind == PK_ITEM);
          if (rec.kind == PK_ITEM) in_item <= rec.op;
          // a drain record holds the sender until nothing is owed
          if (rec.kind != PK_DRAIN || expected_results.size() == 0) begin
            void'(pending_q.pop_front());
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // monitor: every strobe is one result transfer, checked against the oldest
  // -------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    spq_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      status_seen[out_item.status]++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing outstanding: %h", out_item);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("out_position", want.out_position, out_item.out_position);
        check_field("out_key", want.out_key, out_item.out_key);
        check_field("out_payload", want.out_payload, out_item.out_payload);
        check_field("out_priority", want.out_priority, out_item.out_priority);
        check_field("entry_count", want.entry_count, out_item.entry_count);
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------

  // sender gap of some idle cycles, then the operation itself
  task automatic push_op(logic [2:0] f, logic [15:0] k, logic [7:0] pay, logic [7:0] pr,
                         logic [5:0] pos, int gap);
    pending_t rec;
    rec.op = '{func: f, key: k, payload: pay, priority_req: pr, position: pos};
    rec.kind = PK_IDLE;
    repeat (gap) pending_q.push_back(rec);
    rec.kind = PK_ITEM;
    pending_q.push_back(rec);
  endtask

  task automatic push_drain();
    pending_t rec;
    rec = '0;
    rec.kind = PK_DRAIN;
    pending_q.push_back(rec);
  endtask

  // mostly keys from a small pool so that remove, search and change hit
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // coarse priority levels give plenty of ties, the rest is anything
  function automatic logic [7:0] pick_prio();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7) * 36);
  endfunction

  // a run of random operations, mix chosen to fill, churn or empty the queue
  task automatic run_segment(int n, int ins_pct, int rem_pct, int idle_pct);
    int         roll;
    logic [2:0] f;
    int         gap;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) f = spq_pkg::FN_INSERT;
      else if (roll < ins_pct + rem_pct) f = spq_pkg::FN_REMOVE;
      else if (roll < 96) f = 3'($urandom_range(spq_pkg::FN_SEARCH, spq_pkg::FN_READ));
      else f = 3'($urandom_range(spq_pkg::FN_READ + 1, FN_LAST_CODE));
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
      push_op(f, pick_key(), 8'($urandom_range(0, 255)), pick_prio(),
              6'($urandom_range(0, 63)), gap);
    end
  endtask

  initial begin
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 16'($urandom_range(0, 65535));

    // directed: empty queue, extremes, ties, duplicates, re-placing, bounds
    push_op(spq_pkg::FN_READ,   16'h0000, 8'h00, 8'h00, 6'd0,  0);  // read of an empty queue
    push_op(spq_pkg::FN_REMOVE, 16'h0000, 8'h00, 8'h00, 6'd0,  0);
    push_op(spq_pkg::FN_SEARCH, 16'hFFFF, 8'hFF, 8'hFF, 6'd63, 0);
    push_op(spq_pkg::FN_CHANGE, 16'h0000, 8'h00, 8'hFF, 6'd0,  0);
    push_op(spq_pkg::FN_INSERT, 16'h0000, 8'h00, 8'h00, 6'd0,  0);  // lowest priority
    push_op(spq_pkg::FN_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 6'd63, 0);  // goes to the head
    push_op(spq_pkg::FN_INSERT, 16'h1234, 8'h5A, 8'hFF, 6'd0,  0);  // tie, goes behind
    push_op(spq_pkg::FN_INSERT, 16'h1234, 8'hA5, 8'h80, 6'd0,  0);  // duplicate key
    push_op(spq_pkg::FN_SEARCH, 16'h1234, 8'h00, 8'h00, 6'd0,  0);  // first match
    push_op(spq_pkg::FN_CHANGE, 16'h1234, 8'h00, 8'h00, 6'd0,  0);  // down to the tail
    push_op(spq_pkg::FN_CHANGE, 16'h0000, 8'h00, 8'hFF, 6'd0,  0);  // up behind the head
    push_op(spq_pkg::FN_READ,   16'h0000, 8'h00, 8'h00, 6'd63, 0);
    push_op(spq_pkg::FN_READ,   16'h0000, 8'h00, 8'h00, 6'd3,  0);  // last held entry
    push_op(spq_pkg::FN_READ,   16'h0000, 8'h00, 8'h00, 6'd4,  0);  // one past the count
    push_op(spq_pkg::FN_REMOVE, 16'h1234, 8'h00, 8'h00, 6'd0,  0);
    push_op(3'($urandom_range(spq_pkg::FN_READ + 1, FN_LAST_CODE)), 16'hFFFF, 8'hFF, 8'hFF,
            6'd63, 0);
    push_op(FN_LAST_CODE, 16'h0000, 8'h00, 8'h00, 6'd0, 0);
    push_op(spq_pkg::FN_REMOVE, 16'hFFFF, 8'h00, 8'h00, 6'd0,  0);
    push_op(spq_pkg::FN_SEARCH, 16'h0000, 8'h00, 8'h00, 6'd0,  0);
    push_op(spq_pkg::FN_READ,   16'h0000, 8'h00, 8'h00, 6'd1,  0);

    // random: per idling phase, fill to full, churn, then empty out again
    for (int ph = 0; ph < 4; ph++) begin
      push_drain();
      run_segment(100, 80, 4, phase_idle[ph]);
      run_segment(50, 35, 25, phase_idle[ph]);
      run_segment(75, 10, 65, phase_idle[ph]);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // settle on the falling edge, clear of the clocked processes
    do @(negedge clk);
    while (pending_q.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(negedge clk);

    $display("%0d operations sent, %0d results checked, %0d left in the queue",
             ops_sent, results_seen, held_entries);
    $display("status seen: ok %0d, full %0d, not found %0d, beyond count %0d",
             status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_FULL],
             status_seen[spq_pkg::ST_NOTFOUND], status_seen[spq_pkg::ST_BEYOND]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_by_key_core.sv
tb/testbench.sv
